FILE: src/sched_latency_window_monitor_top_macros.svh
// assertion macros shared by the latency window monitor modules
// no dependencies; taken in by `include where assertions are written
`ifndef SCHED_LATENCY_WINDOW_MONITOR_TOP_MACROS_SVH
`define SCHED_LATENCY_WINDOW_MONITOR_TOP_MACROS_SVH

// clocked assertion, disabled while reset is high
`define SLWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SLWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/slwm_pkg.sv
// types, codes and helpers for the scheduling latency window monitor
// used by slwm_core, slwm_outq and the top level; no dependencies
package slwm_pkg;

  localparam int unsigned TS_W    = 64;
  localparam int unsigned TASK_W  = 22;
  localparam int unsigned VEC_W   = 16;
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_IRQ_OFF     = 3'd0,
    OP_IRQ_ON      = 3'd1,
    OP_PREEMPT_OFF = 3'd2,
    OP_PREEMPT_ON  = 3'd3,
    OP_NMI_ENTRY   = 3'd4,
    OP_NMI_EXIT    = 3'd5,
    OP_VECTOR_ID   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    KIND_POID = 3'd0,
    KIND_PAIE = 3'd1,
    KIND_PSD  = 3'd2,
    KIND_DST  = 3'd3,
    KIND_IRQ  = 3'd4,
    KIND_NMI  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [TS_W-1:0]  duration;
    logic             new_max;
    logic [VEC_W-1:0] record_vector;
    logic [TS_W-1:0]  start_time;
    logic             last;
  } rec_t;

  // records produced by one event, slot 0 first
  typedef struct packed {
    logic [1:0] count;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  function automatic rec_t mk_rec(kind_t kind, logic [TS_W-1:0] dur, logic nm,
                                  logic [VEC_W-1:0] vec, logic [TS_W-1:0] st,
                                  logic lst);
    rec_t r;
    r.kind          = kind;
    r.duration      = dur;
    r.new_max       = nm;
    r.record_vector = vec;
    r.start_time    = st;
    r.last          = lst;
    return r;
  endfunction

endpackage

FILE: src/sched_latency_window_monitor_top.sv
// scheduling latency window monitor, top level
// depends on slwm_pkg, slwm_core and slwm_outq
//
// event channel (in_valid/in_ready) carries one timestamped cpu event per transfer;
// result channel (out_valid/out_ready) carries one window record per transfer;
// config channel (cfg_valid/cfg_ready) writes monitor_enable and clears all
// window state and maxima, cfg_ready is always high.
// an event updates the window state in the cycle of its transfer and its records
// enter a four-entry result queue; the first record is offered in the next cycle.
// throughput: one event per cycle while events yield at most one record and the
// receiver takes each record; a schedule return that closes both the tail and psd
// windows yields two records, which leave the queue one per transfer. in_ready is
// high while the queue has at least two free entries, so a stalled receiver holds
// in_ready low once the queue fills and no record is ever dropped.
// reset clears the window state, disables the monitor and empties the queue.
module sched_latency_window_monitor_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  operation,
  input  logic [slwm_pkg::TS_W-1:0]   timestamp,
  input  logic                        variant_flag,
  input  logic                        resched_pending,
  input  logic [slwm_pkg::TASK_W-1:0] task_id,
  input  logic                        irqs_masked,
  input  logic [slwm_pkg::VEC_W-1:0]  vector,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  record_kind,
  output logic [slwm_pkg::TS_W-1:0]   duration,
  output logic                        new_max,
  output logic [slwm_pkg::VEC_W-1:0]  record_vector,
  output logic [slwm_pkg::TS_W-1:0]   start_time,
  output logic                        last
);
  import slwm_pkg::*;

  push_t push;
  rec_t  head;
  logic  room;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;

  slwm_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .accept          (in_valid && in_ready),
    .operation       (operation),
    .timestamp       (timestamp),
    .variant_flag    (variant_flag),
    .resched_pending (resched_pending),
    .task_id         (task_id),
    .irqs_masked     (irqs_masked),
    .vector          (vector),
    .push            (push)
  );

  slwm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign record_kind   = head.kind;
  assign duration      = head.duration;
  assign new_max       = head.new_max;
  assign record_vector = head.record_vector;
  assign start_time    = head.start_time;
  assign last          = head.last;

endmodule

FILE: src/slwm_core.sv
// window state registers and the per-event update logic
// depends on slwm_pkg and the assertion macro header
module slwm_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_data,
  input  logic                       accept,
  input  logic [2:0]                 operation,
  input  logic [slwm_pkg::TS_W-1:0]  timestamp,
  input  logic                       variant_flag,
  input  logic                       resched_pending,
  input  logic [slwm_pkg::TASK_W-1:0] task_id,
  input  logic                       irqs_masked,
  input  logic [slwm_pkg::VEC_W-1:0] vector,
  output slwm_pkg::push_t            push
);
  import slwm_pkg::*;
  `include "sched_latency_window_monitor_top_macros.svh"

  logic              enable;
  logic              running, running_next;
  logic              preempt_off_flag, preempt_off_flag_next;
  logic              irq_off_flag, irq_off_flag_next;
  logic [TS_W-1:0]   poid_start, poid_start_next, poid_max, poid_max_next;
  logic [TS_W-1:0]   paie_start, paie_start_next, paie_max, paie_max_next;
  logic [TS_W-1:0]   psd_start, psd_start_next, psd_max, psd_max_next;
  logic [TASK_W-1:0] tail_task, tail_task_next;
  logic [TS_W-1:0]   tail_start, tail_start_next, tail_max, tail_max_next;
  logic [TS_W-1:0]   irq_arrival, irq_arrival_next, irq_start, irq_start_next;
  logic              irq_in_psd, irq_in_psd_next;
  logic [VEC_W-1:0]  irq_vec_held, irq_vec_held_next;
  logic [TS_W-1:0]   nmi_start, nmi_start_next;

  logic [TS_W-1:0] d_poid, d_paie, d_psd, d_tail, d_irq, d_nmi, push_d;
  logic            close_poid, push_en;
  op_t             op;
  push_t           res;

  assign op     = op_t'(operation);
  assign d_poid = timestamp - poid_start;
  assign d_paie = timestamp - paie_start;
  assign d_psd  = timestamp - psd_start;
  assign d_tail = timestamp - tail_start;
  assign d_irq  = timestamp - irq_start;
  assign d_nmi  = timestamp - nmi_start;

  always_comb begin
    running_next          = running;
    preempt_off_flag_next = preempt_off_flag;
    irq_off_flag_next     = irq_off_flag;
    poid_start_next       = poid_start;
    poid_max_next         = poid_max;
    paie_start_next       = paie_start;
    paie_max_next         = paie_max;
    psd_start_next        = psd_start;
    psd_max_next          = psd_max;
    tail_task_next        = tail_task;
    tail_start_next       = tail_start;
    tail_max_next         = tail_max;
    irq_arrival_next      = irq_arrival;
    irq_start_next        = irq_start;
    irq_in_psd_next       = irq_in_psd;
    irq_vec_held_next     = irq_vec_held;
    nmi_start_next        = nmi_start;
    close_poid            = 1'b0;
    push_en               = 1'b0;
    push_d                = d_nmi;
    res                   = '0;

    if (op == OP_PREEMPT_OFF && variant_flag) begin
      if (running || (enable && !irqs_masked)) begin
        running_next = 1'b1;
        if (resched_pending && irq_start == '0 && !irq_off_flag && paie_start != '0
            && task_id != '0) begin
          if (d_paie >= paie_max) begin
            paie_max_next = d_paie;
          end
          res.count = 2'd1;
          res.r0    = mk_rec(KIND_PAIE, d_paie, d_paie >= paie_max, '0, '0, 1'b1);
        end
        paie_start_next = '0;
        tail_task_next  = task_id;
        psd_start_next  = timestamp;
      end
    end else if (running) begin
      case (op)
        OP_IRQ_OFF: begin
          if (variant_flag) begin
            if (psd_start != '0) begin
              irq_in_psd_next = 1'b1;
            end
            irq_arrival_next = timestamp;
            irq_start_next   = timestamp;
          end else begin
            if (psd_start != '0 && tail_task == task_id) begin
              tail_start_next = timestamp;
            end
            irq_off_flag_next = 1'b1;
            if (poid_start == '0) begin
              poid_start_next = timestamp;
            end
          end
        end
        OP_IRQ_ON: begin
          if (variant_flag) begin
            irq_start_next = '0;
            res.count = 2'd1;
            res.r0    = mk_rec(KIND_IRQ, d_irq, 1'b0, irq_vec_held, irq_arrival, 1'b1);
            push_en   = 1'b1;
            push_d    = d_irq;
            if (irq_in_psd) begin
              psd_start_next = psd_start + d_irq;
            end
            irq_vec_held_next = '0;
            irq_in_psd_next   = 1'b0;
          end else begin
            irq_off_flag_next = 1'b0;
            if (!preempt_off_flag && psd_start == '0) begin
              close_poid = 1'b1;
              if (resched_pending) begin
                paie_start_next = timestamp;
              end
            end
          end
        end
        OP_PREEMPT_OFF: begin
          if (irq_start == '0) begin
            preempt_off_flag_next = 1'b1;
            if (!irq_off_flag) begin
              poid_start_next = timestamp;
            end
          end
        end
        OP_PREEMPT_ON: begin
          if (variant_flag) begin
            if (tail_start != '0) begin
              tail_start_next = '0;
              if (d_tail > tail_max) begin
                tail_max_next = d_tail;
              end
              res.count = 2'd2;
              res.r0    = mk_rec(KIND_DST, d_tail, d_tail > tail_max, '0, '0, 1'b0);
              res.r1    = mk_rec(KIND_PSD, d_psd, d_psd > psd_max, '0, '0, 1'b1);
            end else begin
              res.count = 2'd1;
              res.r0    = mk_rec(KIND_PSD, d_psd, d_psd > psd_max, '0, '0, 1'b1);
            end
            psd_start_next = '0;
            if (d_psd > psd_max) begin
              psd_max_next = d_psd;
            end
            if (resched_pending) begin
              paie_start_next = timestamp;
            end
          end else if (irq_start == '0) begin
            preempt_off_flag_next = 1'b0;
            if (!irq_off_flag) begin
              close_poid = 1'b1;
              if (resched_pending) begin
                paie_start_next = timestamp;
              end
            end
          end
        end
        OP_NMI_ENTRY: begin
          nmi_start_next = timestamp;
        end
        OP_NMI_EXIT: begin
          res.count = 2'd1;
          res.r0    = mk_rec(KIND_NMI, d_nmi, 1'b0, '0, nmi_start, 1'b1);
          if (irq_start != '0) begin
            irq_start_next = irq_start + d_nmi;
          end
          if (psd_start != '0) begin
            psd_start_next = psd_start + d_nmi;
          end
          push_en = 1'b1;
        end
        OP_VECTOR_ID: begin
          irq_vec_held_next = vector;
        end
        default: begin
        end
      endcase
    end

    if (close_poid && poid_start != '0) begin
      poid_start_next = '0;
      if (task_id != '0) begin
        if (d_poid >= poid_max) begin
          poid_max_next = d_poid;
        end
        res.count = 2'd1;
        res.r0    = mk_rec(KIND_POID, d_poid, d_poid >= poid_max, '0, '0, 1'b1);
      end
    end

    if (push_en) begin
      if (poid_start != '0) begin
        poid_start_next = poid_start + push_d;
      end
      if (tail_start != '0) begin
        tail_start_next = tail_start + push_d;
      end
      if (paie_start != '0) begin
        paie_start_next = paie_start + push_d;
      end
    end
  end

  always_comb begin
    push = res;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      running          <= 1'b0;
      preempt_off_flag <= 1'b0;
      irq_off_flag     <= 1'b0;
      poid_start       <= '0;
      poid_max         <= '0;
      paie_start       <= '0;
      paie_max         <= '0;
      psd_start        <= '0;
      psd_max          <= '0;
      tail_task        <= '0;
      tail_start       <= '0;
      tail_max         <= '0;
      irq_arrival      <= '0;
      irq_start        <= '0;
      irq_in_psd       <= 1'b0;
      irq_vec_held     <= '0;
      nmi_start        <= '0;
    end else if (accept) begin
      running          <= running_next;
      preempt_off_flag <= preempt_off_flag_next;
      irq_off_flag     <= irq_off_flag_next;
      poid_start       <= poid_start_next;
      poid_max         <= poid_max_next;
      paie_start       <= paie_start_next;
      paie_max         <= paie_max_next;
      psd_start        <= psd_start_next;
      psd_max          <= psd_max_next;
      tail_task        <= tail_task_next;
      tail_start       <= tail_start_next;
      tail_max         <= tail_max_next;
      irq_arrival      <= irq_arrival_next;
      irq_start        <= irq_start_next;
      irq_in_psd       <= irq_in_psd_next;
      irq_vec_held     <= irq_vec_held_next;
      nmi_start        <= nmi_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_data;
    end
  end

  `SLWM_ASSERT(a_cfg_stops, clk, rst, cfg_we |=> !running, "config write left monitor running")
  `SLWM_ASSERT(a_run_holds, clk, rst, running && !cfg_we |=> running, "monitor stopped by itself")
  `SLWM_ASSERT(a_start_needs_en, clk, rst, !running && !cfg_we && !enable |=> !running,
               "monitor started while disabled")
  `SLWM_ASSERT(a_pair_only_psd, clk, rst, push.count == 2'd2 |-> op == OP_PREEMPT_ON,
               "two records from an event other than schedule return")

endmodule

FILE: src/slwm_outq.sv
// result queue: takes up to two records per event, sends one per transfer
// depends on slwm_pkg and the assertion macro header
module slwm_outq (
  input  logic            clk,
  input  logic            rst,
  input  slwm_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output slwm_pkg::rec_t  head
);
  import slwm_pkg::*;
  `include "sched_latency_window_monitor_top_macros.svh"

  rec_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OQ_CNT_W-1:0] count, count_next;
  logic                pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = count != '0;
  assign room       = count <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign head       = mem[rd_ptr];
  assign count_next = count + OQ_CNT_W'(push.count) - OQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + OQ_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  `SLWM_ASSERT_ALWAYS(a_no_overflow, clk, rst || count <= OQ_CNT_W'(OQ_DEPTH),
                      "result queue overflow")
  `SLWM_ASSERT(a_push_with_room, clk, rst, push.count != 2'd0 |-> room,
               "records pushed without room")
  `SLWM_ASSERT(a_count_track, clk, rst, push.count == 2'd0 && !pop |=> $stable(count),
               "queue count moved without transfer")

endmodule
